// File: hdl/key_press_relay_control_defines.svh
// ---------------------------------------------------------------------------
// key press relay control assertion macros
// shared concurrent check macros, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef KEY_PRESS_RELAY_CONTROL_DEFINES_SVH
`define KEY_PRESS_RELAY_CONTROL_DEFINES_SVH

`ifndef SYNTH
// property holds on every clock edge outside reset
`define KPRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression never true outside reset
`define KPRC_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KPRC_ASSERT(lbl, prop, msg)
`define KPRC_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// File: hdl/kprc_pkg.sv
// ---------------------------------------------------------------------------
// kprc_pkg
// shared types and constants of the key press relay controller
// ---------------------------------------------------------------------------
package kprc_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // register field widths
    localparam int THRESH_W = 16;
    localparam int SETTLE_W = 8;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOCK_MODE   = 2'd0,
        CFG_LONG_PRESS  = 2'd1,
        CFG_SHORT_PRESS = 2'd2,
        CFG_SETTLE      = 2'd3
    } cfg_reg_e;

    // register reset values
    localparam logic [THRESH_W-1:0] LONG_PRESS_RESET  = 16'd1000;
    localparam logic [THRESH_W-1:0] SHORT_PRESS_RESET = 16'd20;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET      = 8'd2;

    // classified release of one key in the current transaction
    typedef struct packed {
        logic long_press;
        logic short_press;
    } key_event_t;

endpackage

// File: hdl/kprc_key_channel.sv
// ---------------------------------------------------------------------------
// kprc_key_channel
// per-key settle counter, press timer and release classification
// ---------------------------------------------------------------------------
`include "key_press_relay_control_defines.svh"

module kprc_key_channel
    import kprc_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic                level,
    input  logic [SETTLE_W-1:0] settle_load,
    input  logic [THRESH_W-1:0] long_press_ticks,
    input  logic [THRESH_W-1:0] short_press_ticks,
    output key_event_t          key_event
);

    localparam int CMP_W = (TIMER_WIDTH > THRESH_W) ? TIMER_WIDTH : THRESH_W;

    logic                   prev_level_reg, prev_level_next;
    logic                   sampled_reg, sampled_next;
    logic [SETTLE_W-1:0]    settle_reg, settle_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;

    logic                   timer_sat;
    logic [TIMER_WIDTH-1:0] timer_inc;
    logic                   sample;
    logic                   release_hit;
    logic [CMP_W-1:0]       held_ext;
    logic                   over_long;
    logic                   over_short;

    assign timer_sat = (timer_reg == {TIMER_WIDTH{1'b1}});
    assign timer_inc = timer_sat ? timer_reg : timer_reg + TIMER_WIDTH'(1);
    assign held_ext  = CMP_W'(timer_inc);
    assign over_long  = held_ext > CMP_W'(long_press_ticks);
    assign over_short = held_ext > CMP_W'(short_press_ticks);

    always_comb
    begin
        settle_next = settle_reg;
        sample      = 1'b0;
        if (level != prev_level_reg)
        begin
            settle_next = settle_load;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - SETTLE_W'(1);
            sample      = (settle_reg == SETTLE_W'(1));
        end

        timer_next   = timer_inc;
        sampled_next = sampled_reg;
        release_hit  = 1'b0;
        if (sample)
        begin
            if (!level)
            begin
                // press seen, restart timing
                timer_next   = '0;
                sampled_next = 1'b0;
            end
            else
            begin
                release_hit  = !sampled_reg;
                sampled_next = 1'b1;
            end
        end

        prev_level_next = level;

        key_event.long_press  = release_hit && over_long;
        key_event.short_press = release_hit && !over_long && over_short;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            sampled_reg    <= 1'b1;
            settle_reg     <= '0;
            timer_reg      <= '0;
        end
        else if (enable)
        begin
            prev_level_reg <= prev_level_next;
            sampled_reg    <= sampled_next;
            settle_reg     <= settle_next;
            timer_reg      <= timer_next;
        end
    end

    // a classified release only comes from an expiring counter on a quiet tick
    `KPRC_ASSERT(a_event_on_expiry,
        (key_event.long_press || key_event.short_press) |->
            (settle_reg == SETTLE_W'(1) && level == prev_level_reg && !sampled_reg),
        "key event without settle expiry after a press")

endmodule

// File: hdl/kprc_relay_logic.sv
// ---------------------------------------------------------------------------
// kprc_relay_logic
// applies key events in ascending key order to relay state and long flag
// ---------------------------------------------------------------------------
`include "key_press_relay_control_defines.svh"

module kprc_relay_logic
    import kprc_pkg::*;
#(
    parameter int NUM_KEYS = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            enable,
    input  logic                            lock_mode,
    input  key_event_t [NUM_KEYS-1:0]       key_events,
    output logic [NUM_KEYS-1:0]             relay_next,
    output logic [NUM_KEYS-1:0]             start_next,
    output logic [NUM_KEYS-1:0]             stop_next,
    output logic [NUM_KEYS-1:0]             toggle_next,
    output logic                            long_flag_next
);

    logic [NUM_KEYS-1:0] relay_reg;
    logic                long_flag_reg;
    logic [NUM_KEYS-1:0] others;

    always_comb
    begin
        relay_next     = relay_reg;
        start_next     = '0;
        stop_next      = '0;
        toggle_next    = '0;
        long_flag_next = long_flag_reg;
        others         = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            others    = '1;
            others[k] = 1'b0;
            if (key_events[k].long_press)
            begin
                long_flag_next = 1'b1;
            end
            else if (key_events[k].short_press)
            begin
                toggle_next[k] = 1'b1;
                if (!relay_next[k])
                begin
                    relay_next[k] = 1'b1;
                    start_next[k] = 1'b1;
                    if (lock_mode)
                    begin
                        relay_next = relay_next & ~others;
                        stop_next  = stop_next | others;
                    end
                end
                else
                begin
                    relay_next[k] = 1'b0;
                    stop_next[k]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg     <= '0;
            long_flag_reg <= 1'b0;
        end
        else if (enable)
        begin
            relay_reg     <= relay_next;
            long_flag_reg <= long_flag_next;
        end
    end

    `KPRC_ASSERT(a_long_flag_sticky, long_flag_reg |=> long_flag_reg,
        "long press flag cleared outside reset")
    `KPRC_ASSERT_NEVER(a_toggle_has_change, (toggle_next & ~(start_next | stop_next)) != '0,
        "toggle reported without relay change")

endmodule

// File: hdl/kprc_out_buffer.sv
// ---------------------------------------------------------------------------
// kprc_out_buffer
// result register with one skid entry that takes one more input under stall
// ---------------------------------------------------------------------------
`include "key_press_relay_control_defines.svh"

module kprc_out_buffer
#(
    parameter int WIDTH = 17
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_load,
    input  logic [WIDTH-1:0] in_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg, skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_load;
                out_data_next  = in_data;
            end
        end
        else if (in_load)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `KPRC_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg,
        "skid entry held while output register empty")
    `KPRC_ASSERT(a_skid_catches, (in_load && out_valid_reg && out_stall) |=> skid_valid_reg,
        "transaction under stall not captured in skid entry")

endmodule

// File: hdl/key_press_relay_control.sv
// ---------------------------------------------------------------------------
// key_press_relay_control
// debounced key short/long press detection driving toggled relays
// ---------------------------------------------------------------------------
// usage
//   input channel: one transaction per system tick carrying raw key levels
//   (in_valid, in_stall, key_levels); bit k is key k, low means pressed
//   output channel: exactly one result transaction per input transaction
//   (out_valid, out_stall, relay levels, pulse start/stop masks, toggle mask,
//   sticky long press flag)
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high, write only while no transaction is in flight
//   result path: all per-key counters and the ascending relay chain are
//   combinational between accept and the result register, which is loaded
//   directly, or from the skid entry after a stall
//   throughput: one transaction per cycle while in_stall is low
//   stall: a result waiting under out_stall does not block the next input,
//   which lands in a one-entry skid; in_stall rises only when that skid fills
//   reset: relays off, long flag clear, keys seen released, counters idle,
//   registers at their default values, both channels empty
// ---------------------------------------------------------------------------
module key_press_relay_control
    import kprc_pkg::*;
#(
    parameter int NUM_KEYS    = 4,
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [NUM_KEYS-1:0]    key_levels,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [NUM_KEYS-1:0]    relay_levels,
    output logic [NUM_KEYS-1:0]    pulse_start_mask,
    output logic [NUM_KEYS-1:0]    pulse_stop_mask,
    output logic [NUM_KEYS-1:0]    toggle_mask,
    output logic                   long_press_flag,
    // config channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int RESULT_W = 4 * NUM_KEYS + 1;

    // configuration registers
    logic                lock_mode_reg;
    logic [THRESH_W-1:0] long_press_reg;
    logic [THRESH_W-1:0] short_press_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_load;

    logic                      accept;
    logic                      skid_full;
    key_event_t [NUM_KEYS-1:0] key_events;

    logic [NUM_KEYS-1:0] relay_next;
    logic [NUM_KEYS-1:0] start_next;
    logic [NUM_KEYS-1:0] stop_next;
    logic [NUM_KEYS-1:0] toggle_next;
    logic                long_flag_next;
    logic [RESULT_W-1:0] result_next;
    logic [RESULT_W-1:0] result_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_mode_reg   <= 1'b0;
            long_press_reg  <= LONG_PRESS_RESET;
            short_press_reg <= SHORT_PRESS_RESET;
            settle_reg      <= SETTLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_LOCK_MODE:   lock_mode_reg   <= cfg_data[0];
                CFG_LONG_PRESS:  long_press_reg  <= cfg_data[THRESH_W-1:0];
                CFG_SHORT_PRESS: short_press_reg <= cfg_data[THRESH_W-1:0];
                CFG_SETTLE:      settle_reg      <= cfg_data[SETTLE_W-1:0];
            endcase
        end
    end

    // a settle time of zero behaves as one
    assign settle_load = (settle_reg == '0) ? SETTLE_W'(1) : settle_reg;

    // skid full is the only back pressure on the input
    assign in_stall = skid_full;
    assign accept   = in_valid && !in_stall;

    // one debounce and press timer per key
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        kprc_key_channel #(
            .TIMER_WIDTH (TIMER_WIDTH)
        ) u_key (
            .clk               (clk),
            .rst_n             (rst_n),
            .enable            (accept),
            .level             (key_levels[k]),
            .settle_load       (settle_load),
            .long_press_ticks  (long_press_reg),
            .short_press_ticks (short_press_reg),
            .key_event         (key_events[k])
        );
    end

    // events resolved in ascending key order against relay state
    kprc_relay_logic #(
        .NUM_KEYS (NUM_KEYS)
    ) u_relay (
        .clk            (clk),
        .rst_n          (rst_n),
        .enable         (accept),
        .lock_mode      (lock_mode_reg),
        .key_events     (key_events),
        .relay_next     (relay_next),
        .start_next     (start_next),
        .stop_next      (stop_next),
        .toggle_next    (toggle_next),
        .long_flag_next (long_flag_next)
    );

    assign result_next = {relay_next, start_next, stop_next, toggle_next, long_flag_next};

    // result register plus skid entry
    kprc_out_buffer #(
        .WIDTH (RESULT_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_load   (accept),
        .in_data   (result_next),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (result_out)
    );

    assign relay_levels     = result_out[4*NUM_KEYS:3*NUM_KEYS+1];
    assign pulse_start_mask = result_out[3*NUM_KEYS:2*NUM_KEYS+1];
    assign pulse_stop_mask  = result_out[2*NUM_KEYS:NUM_KEYS+1];
    assign toggle_mask      = result_out[NUM_KEYS:1];
    assign long_press_flag  = result_out[0];

endmodule

// File: verif/key_press_relay_control_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_press_relay_control_tb
// self-checking bench: drives raw key levels tick by tick and compares every
// result transaction with a cycle-true prediction of debounce, press timing,
// short/long classification and relay toggling under several register setups
// ---------------------------------------------------------------------------
module key_press_relay_control_tb;
    import kprc_pkg::*;

    localparam int KEYS = 4;
    localparam int unsigned CYCLE_LIMIT = 50_000;
    // receiver hold-off length, long enough to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 48;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic [KEYS-1:0] relays;
        logic [KEYS-1:0] starts;
        logic [KEYS-1:0] stops;
        logic [KEYS-1:0] toggles;
        logic            long_flag;
    } relay_result_t;

    // -----------------------------------------------------------------------
    // prediction of the relay controller and store of pending results
    // -----------------------------------------------------------------------
    class relay_scoreboard;
        // register copy, reset values
        bit                lock_on   = 1'b0;
        bit [THRESH_W-1:0] long_thr  = LONG_PRESS_RESET;
        bit [THRESH_W-1:0] short_thr = SHORT_PRESS_RESET;
        bit [SETTLE_W-1:0] settle    = SETTLE_RESET;
        // key and relay state
        bit [KEYS-1:0]     last_raw     = '1;
        bit [KEYS-1:0]     debounced    = '1;
        bit [KEYS-1:0]     relays       = '0;
        bit                long_seen    = 1'b0;
        bit [SETTLE_W-1:0] settle_cnt [KEYS];
        bit [15:0]         hold_cnt   [KEYS];
        relay_result_t     expected_q [$];
        int                errors = 0;

        function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LOCK_MODE:   lock_on   = value[0];
                CFG_LONG_PRESS:  long_thr  = value;
                CFG_SHORT_PRESS: short_thr = value;
                CFG_SETTLE:      settle    = value[SETTLE_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted tick of raw key levels
        function void note_keys(logic [KEYS-1:0] raw);
            bit [KEYS-1:0]     starts;
            bit [KEYS-1:0]     stops;
            bit [KEYS-1:0]     toggles;
            bit [KEYS-1:0]     others;
            bit [SETTLE_W-1:0] reload;
            bit                sample;
            relay_result_t     want;
            starts  = '0;
            stops   = '0;
            toggles = '0;
            // a settle time of zero acts as one
            reload  = (settle == 0) ? SETTLE_W'(1) : settle;
            // keys in ascending order, each sees the relays the previous left
            for (int k = 0; k < KEYS; k++)
            begin
                sample = 1'b0;
                if (hold_cnt[k] != 16'hFFFF)
                    hold_cnt[k]++;
                if (raw[k] != last_raw[k])
                    settle_cnt[k] = reload;
                else if (settle_cnt[k] != 0)
                begin
                    settle_cnt[k]--;
                    sample = (settle_cnt[k] == 0);
                end
                if (sample)
                begin
                    if (!raw[k])
                    begin
                        // every low sample restarts the press timer
                        hold_cnt[k]  = '0;
                        debounced[k] = 1'b0;
                    end
                    else
                    begin
                        if (!debounced[k])
                        begin
                            if (hold_cnt[k] > long_thr)
                                long_seen = 1'b1;
                            else if (hold_cnt[k] > short_thr)
                            begin
                                toggles[k] = 1'b1;
                                if (!relays[k])
                                begin
                                    relays[k] = 1'b1;
                                    starts[k] = 1'b1;
                                    if (lock_on)
                                    begin
                                        others = ~(KEYS'(1) << k);
                                        relays &= ~others;
                                        stops  |= others;
                                    end
                                end
                                else
                                begin
                                    relays[k] = 1'b0;
                                    stops[k]  = 1'b1;
                                end
                            end
                        end
                        debounced[k] = 1'b1;
                    end
                end
            end
            last_raw = raw;
            want.relays    = relays;
            want.starts    = starts;
            want.stops     = stops;
            want.toggles   = toggles;
            want.long_flag = long_seen;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [KEYS-1:0] want, logic [KEYS-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(relay_result_t got);
            relay_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("relay_levels", want.relays, got.relays);
            compare_field("pulse_start_mask", want.starts, got.starts);
            compare_field("pulse_stop_mask", want.stops, got.stops);
            compare_field("toggle_mask", want.toggles, got.toggles);
            compare_field("long_press_flag", KEYS'(want.long_flag), KEYS'(got.long_flag));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // clock, reset and block ports, the driven ones at known values from time zero
    // -----------------------------------------------------------------------
    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic [KEYS-1:0]        key_levels = '1;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic [KEYS-1:0]        relay_levels;
    logic [KEYS-1:0]        pulse_start_mask;
    logic [KEYS-1:0]        pulse_stop_mask;
    logic [KEYS-1:0]        toggle_mask;
    logic                   long_press_flag;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = CFG_LOCK_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    relay_scoreboard relay_sb = new();

    // idle percentages of the two sides, changed per phase
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    // set by the stimulus to ask the receiver for one long hold-off
    bit          hold_request = 1'b0;
    int          stall_left   = 0;
    int unsigned keys_sent    = 0;
    int unsigned cycle_count  = 0;

    // opening ticks at reset defaults (settle of two): all keys at once,
    // alternating pairs, single-tick bounces and a glitch that re-samples low
    logic [KEYS-1:0] opening_ticks [24] = '{
        4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 4'hF,
        4'h5, 4'hA, 4'h5, 4'hA, 4'hF, 4'hF, 4'hF, 4'hE,
        4'hF, 4'hE, 4'hE, 4'hE, 4'hF, 4'hF, 4'hF, 4'h7
    };

    always #10 clk = ~clk;

    key_press_relay_control DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .key_levels       (key_levels),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .relay_levels     (relay_levels),
        .pulse_start_mask (pulse_start_mask),
        .pulse_stop_mask  (pulse_stop_mask),
        .toggle_mask      (toggle_mask),
        .long_press_flag  (long_press_flag),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // -----------------------------------------------------------------------
    // receiver: checks each accepted result, then picks next cycle's stall
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            relay_sb.check_result({relay_levels, pulse_start_mask, pulse_stop_mask,
                                   toggle_mask, long_press_flag});
        if (stall_left > 0)
        begin
            // long hold-off in progress, sender keeps offering meanwhile
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            stall_left  <= HOLD_OFF_CYCLES;
            out_stall   <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // watchdog on a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("key_press_relay_control_tb: errors");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // input channel: one tick of raw levels per transaction
    // -----------------------------------------------------------------------
    task automatic send_keys(logic [KEYS-1:0] levels);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_levels <= levels;
        // transaction completes on the first edge without input stall
        do @(posedge clk); while (in_stall);
        relay_sb.note_keys(levels);
        keys_sent++;
    endtask

    // wait until every predicted result has been checked
    task automatic drain();
        in_valid <= 1'b0;
        while (relay_sb.outstanding() != 0) @(posedge clk);
        // spare edges before touching registers
        repeat (4) @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // config channel
    // -----------------------------------------------------------------------
    task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        relay_sb.set_reg(idx, value);
    endtask

    task automatic configure(bit lock_val, logic [THRESH_W-1:0] long_val,
                             logic [THRESH_W-1:0] short_val, logic [SETTLE_W-1:0] settle_val);
        write_reg(CFG_LOCK_MODE, {{(CFG_DATA_W-1){1'b0}}, lock_val});
        write_reg(CFG_LONG_PRESS, long_val);
        write_reg(CFG_SHORT_PRESS, short_val);
        write_reg(CFG_SETTLE, {{(CFG_DATA_W-SETTLE_W){1'b0}}, settle_val});
        cfg_valid <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // press generation
    // -----------------------------------------------------------------------
    // hold length, biased onto both sides of each threshold when in range
    function automatic int unsigned pick_hold(int unsigned lo, int unsigned hi);
        int unsigned thr_pick;
        case ($urandom_range(5))
            0: thr_pick = relay_sb.short_thr;
            1: thr_pick = relay_sb.short_thr + 1;
            2: thr_pick = relay_sb.long_thr;
            3: thr_pick = relay_sb.long_thr + 1;
            default: thr_pick = $urandom_range(hi, lo);
        endcase
        if (thr_pick > hi)
            thr_pick = $urandom_range(hi, lo);
        return thr_pick;
    endfunction

    // one press of one or more keys, optionally with contact bounce around
    // the edges, followed by enough released ticks to sample the release
    task automatic press_burst(int unsigned lo, int unsigned hi);
        logic [KEYS-1:0] pressed;
        logic [KEYS-1:0] levels;
        int unsigned     first [KEYS];
        int unsigned     span  [KEYS];
        int unsigned     len;
        int unsigned     stop_at;
        bit              bouncy;
        bit              same_timing;
        if ($urandom_range(3) == 0)
            pressed = KEYS'($urandom_range(15, 1));
        else
            pressed = 4'b0001 << $urandom_range(KEYS - 1);
        bouncy      = 1'($urandom_range(1));
        same_timing = 1'($urandom_range(1));
        len = 0;
        for (int k = 0; k < KEYS; k++)
        begin
            if (same_timing && k > 0)
            begin
                first[k] = first[0];
                span[k]  = span[0];
            end
            else
            begin
                first[k] = $urandom_range(2);
                span[k]  = pick_hold(lo, hi);
            end
            if (pressed[k] && first[k] + span[k] > len)
                len = first[k] + span[k];
        end
        len += ((relay_sb.settle == 0) ? 1 : relay_sb.settle) + 1 + $urandom_range(3);
        for (int unsigned t = 0; t < len; t++)
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                stop_at   = first[k] + span[k];
                levels[k] = !(pressed[k] && t >= first[k] && t < stop_at);
                // chatter within a tick of either edge
                if (bouncy && pressed[k] && span[k] != 0 &&
                    ((t + 1 >= first[k] && t <= first[k]) ||
                     (t + 1 >= stop_at && t <= stop_at)) &&
                    $urandom_range(2) == 0)
                    levels[k] = ~levels[k];
            end
            send_keys(levels);
        end
    endtask

    // mostly clean press sequences, some raw noise in between
    task automatic random_phase(int unsigned lo, int unsigned hi, int unsigned budget);
        int unsigned phase_start;
        phase_start = keys_sent;
        while (keys_sent - phase_start < budget)
        begin
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(4, 1)) send_keys(KEYS'($urandom_range(15, 0)));
            else
                press_burst(lo, hi);
        end
    endtask

    // -----------------------------------------------------------------------
    // test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles often, receiver stalls more often
        tx_idle_pct = 37;
        rx_idle_pct = 72;

        // reset defaults: edges, bounce, no press long enough to toggle
        foreach (opening_ticks[i])
            send_keys(opening_ticks[i]);
        // presses around the default short threshold, flag must stay clear
        random_phase(10, 30, 250);
        drain();

        // lock mode with small thresholds, plus a long receiver hold-off
        configure(1'b1, 16'd12, 16'd3, 8'd1);
        hold_request = 1'b1;
        random_phase(0, 16, 200);
        drain();

        // other way round: receiver stalls less than the sender idles
        tx_idle_pct = 72;
        rx_idle_pct = 37;

        // short threshold above long one: nothing toggles; settle of zero
        configure(1'b1, 16'd0, 16'hFFFF, 8'd0);
        random_phase(0, 6, 120);
        drain();

        // lock mode, wide window between thresholds, slower settle
        configure(1'b1, 16'd30, 16'd1, 8'd4);
        hold_request = 1'b1;
        random_phase(0, 34, 200);
        drain();

        // no idling from here on
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        // long threshold at its maximum and short at zero: a long hold of
        // two keys still counts as a short press and toggles both relays
        configure(1'b0, 16'hFFFF, 16'd0, 8'd40);
        repeat (3) send_keys(4'hF);
        repeat (80) send_keys(4'b1010);
        repeat (50) send_keys(4'hF);
        drain();

        // plain toggling without lock
        configure(1'b0, 16'd20, 16'd6, 8'd2);
        random_phase(0, 24, 120);
        drain();

        if (relay_sb.errors == 0 && relay_sb.outstanding() == 0)
            $display("key_press_relay_control_tb: clean");
        else
            $display("key_press_relay_control_tb: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/kprc_pkg.sv
hdl/kprc_key_channel.sv
hdl/kprc_relay_logic.sv
hdl/kprc_out_buffer.sv
hdl/key_press_relay_control.sv
verif/key_press_relay_control_tb.sv
